FILE: design/pbs_pkg.sv
// Shared types and constants for the positional bag store.
// Request and result records, operation and status codes, sequencer states.
// No dependencies.
`default_nettype none

package pbs_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W     = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 3;
    localparam int DOUT_W   = 32;
    localparam int SIZE_W   = 9;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 4'd0,
        OP_REMOVE   = 4'd1,
        OP_CONTAINS = 4'd2,
        OP_COUNT    = 4'd3,
        OP_GET      = 4'd4,
        OP_SET      = 4'd5,
        OP_INSERT   = 4'd6,
        OP_PUSHBACK = 4'd7,
        OP_POPFRONT = 4'd8,
        OP_POPBACK  = 4'd9,
        OP_CLEAR    = 4'd10
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HEAD_RD,
        S_HEAD_WR,
        S_GET,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                       op;
        logic signed [VALUE_W-1:0] value;
        logic signed [POS_W-1:0]   pos;
    } t_req;

    typedef struct packed {
        t_status                  status;
        logic signed [DOUT_W-1:0] data;
        logic [SIZE_W-1:0]        size;
    } t_result;

endpackage

`default_nettype wire

FILE: design/positional_bag_store.sv
// Positional bag store: top level with entry RAM, sequencer and result register.
// Depends on pbs_pkg, pbs_ram and pbs_seq.
//
// Bounded ordered store of up to CAPACITY signed words kept in one RAM as a
// circular buffer (head pointer plus count). Add, push back, pops, clear and
// set go straight from acceptance to the result; get makes one RAM read first.
// Contains and count read every held entry through the single RAM read port.
// Remove scans up to the first match, then reads the head and writes it over
// the match. Insert moves the entries from the position to the end back by
// one, one RAM read and write per cycle. One transaction is worked on at a
// time; the next can be taken in the cycle after the result enters the output
// register, which holds it until the consumer takes it.
`default_nettype none

module positional_bag_store #(
    parameter int CAPACITY   = pbs_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pbs_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic        [pbs_pkg::OP_W-1:0]      i_op,
    input  wire logic signed [pbs_pkg::VALUE_W-1:0]   i_value,
    input  wire logic signed [pbs_pkg::POS_W-1:0]     i_pos,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic             [pbs_pkg::STATUS_W-1:0]  o_status,
    output logic signed      [pbs_pkg::DOUT_W-1:0]    o_data,
    output logic             [pbs_pkg::SIZE_W-1:0]    o_size
);

    localparam int AW = $clog2(CAPACITY);

    pbs_pkg::t_req    w_req;
    pbs_pkg::t_result w_res;
    logic             w_res_valid;
    logic             w_res_stall;
    logic             w_load;

    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [DATA_WIDTH-1:0] w_rd_data;

    logic             r_out_valid, n_out_valid;
    pbs_pkg::t_result r_out, n_out;

    assign w_req.op    = pbs_pkg::t_op'(i_op);
    assign w_req.value = i_value;
    assign w_req.pos   = i_pos;

    pbs_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .o_req_stall (o_stall),
        .i_req       (w_req),
        .o_res_valid (w_res_valid),
        .i_res_stall (w_res_stall),
        .o_res       (w_res),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    pbs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // output register
    assign w_res_stall = r_out_valid && i_stall;
    assign w_load      = w_res_valid && !w_res_stall;

    always_comb begin
        n_out_valid = w_load || (r_out_valid && i_stall);
        n_out       = w_load ? w_res : r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out.status;
    assign o_data   = r_out.data;
    assign o_size   = r_out.size;

endmodule

`default_nettype wire

FILE: design/pbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/pbs_seq.sv
// Sequencer for the positional bag store: circular head/count pointers,
// scan, shift and read-modify-write steps against the entry RAM.
// Depends on pbs_pkg.
`default_nettype none

module pbs_seq #(
    parameter int CAPACITY   = pbs_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pbs_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    output logic                             o_req_stall,
    input  wire pbs_pkg::t_req               i_req,
    output logic                             o_res_valid,
    input  wire logic                        i_res_stall,
    output pbs_pkg::t_result                 o_res,
    output logic                             o_wr_en,
    output logic [$clog2(CAPACITY)-1:0]      o_wr_addr,
    output logic [DATA_WIDTH-1:0]            o_wr_data,
    output logic                             o_rd_en,
    output logic [$clog2(CAPACITY)-1:0]      o_rd_addr,
    input  wire logic [DATA_WIDTH-1:0]       i_rd_data
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SUMW = CW + 1;
    localparam int SW   = (CW + 2 > pbs_pkg::POS_W + 1) ? CW + 2 : pbs_pkg::POS_W + 1;
    localparam int SZW  = pbs_pkg::SIZE_W;
    localparam int DOW  = pbs_pkg::DOUT_W;
    localparam int DW   = DATA_WIDTH;

    pbs_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    pbs_pkg::t_op     r_op, n_op;
    logic [DW-1:0]    r_val, n_val;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_hits, n_hits;
    logic [AW-1:0]    r_match, n_match;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_pend_addr, n_pend_addr;
    pbs_pkg::t_result r_res, n_res;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic [DW-1:0]    w_val;
    logic signed [SW-1:0] w_pos;
    logic signed [SW-1:0] w_cnt;
    logic signed [SW-1:0] w_neg_idx;
    logic signed [SW-1:0] w_res_idx;
    logic [CW-1:0]    w_idx;
    logic             w_pos_ok;
    logic             w_ins_ok;
    logic [AW-1:0]    w_head_inc;
    logic [AW-1:0]    w_head_dec;
    logic             w_match;
    logic             w_scan_end;
    logic             w_shift_end;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [CW-1:0] ofs);
        logic [SUMW-1:0] sum;
        sum = SUMW'(base) + SUMW'(ofs);
        if (sum >= SUMW'(CAPACITY)) begin
            sum = sum - SUMW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign w_accept    = i_req_valid && (r_state == pbs_pkg::S_IDLE);
    assign o_req_stall = (r_state != pbs_pkg::S_IDLE);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_val       = DW'($signed(i_req.value));

    assign w_pos     = SW'($signed(i_req.pos));
    assign w_cnt     = SW'(r_count);
    assign w_neg_idx = w_cnt + w_pos;
    assign w_pos_ok  = w_pos[SW-1] ? (w_neg_idx >= 0) : (w_pos < w_cnt);
    assign w_res_idx = w_pos[SW-1] ? w_neg_idx : w_pos;
    assign w_idx     = w_res_idx[CW-1:0];
    assign w_ins_ok  = !w_pos[SW-1] && (w_pos <= w_cnt);

    assign w_head_inc = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);
    assign w_head_dec = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);

    assign w_match     = r_pend && (i_rd_data == r_val);
    assign w_scan_end  = !r_pend && (r_idx == r_count);
    assign w_shift_end = !r_pend && (r_idx == r_pos);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pbs_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_req.op)
                        pbs_pkg::OP_GET: begin
                            n_state = w_pos_ok ? pbs_pkg::S_GET : pbs_pkg::S_DONE;
                        end
                        pbs_pkg::OP_COUNT, pbs_pkg::OP_CONTAINS, pbs_pkg::OP_REMOVE: begin
                            n_state = pbs_pkg::S_SCAN;
                        end
                        pbs_pkg::OP_INSERT: begin
                            n_state = (w_ins_ok && !w_full) ? pbs_pkg::S_SHIFT
                                                            : pbs_pkg::S_DONE;
                        end
                        default: begin
                            n_state = pbs_pkg::S_DONE;
                        end
                    endcase
                end
            end
            pbs_pkg::S_SCAN: begin
                priority if (r_op == pbs_pkg::OP_REMOVE && w_match) begin
                    n_state = pbs_pkg::S_HEAD_RD;
                end else if (w_scan_end) begin
                    n_state = pbs_pkg::S_DONE;
                end else begin
                    n_state = pbs_pkg::S_SCAN;
                end
            end
            pbs_pkg::S_HEAD_RD: n_state = pbs_pkg::S_HEAD_WR;
            pbs_pkg::S_HEAD_WR: n_state = pbs_pkg::S_DONE;
            pbs_pkg::S_GET:     n_state = pbs_pkg::S_DONE;
            pbs_pkg::S_SHIFT: begin
                if (w_shift_end) begin
                    n_state = pbs_pkg::S_DONE;
                end
            end
            pbs_pkg::S_DONE: begin
                if (!i_res_stall) begin
                    n_state = pbs_pkg::S_IDLE;
                end
            end
            default: n_state = pbs_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_op        = r_op;
        n_val       = r_val;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_hits      = r_hits;
        n_match     = r_match;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_res       = r_res;
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        o_wr_data   = r_val;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        o_res_valid = 1'b0;

        unique case (r_state)
            pbs_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op        = i_req.op;
                    n_val       = w_val;
                    n_idx       = '0;
                    n_hits      = '0;
                    n_res.status = pbs_pkg::ST_OK;
                    n_res.data   = '0;
                    unique case (i_req.op)
                        pbs_pkg::OP_ADD: begin
                            if (w_full) begin
                                n_res.status = pbs_pkg::ST_FULL;
                            end else begin
                                n_head    = w_head_dec;
                                o_wr_en   = 1'b1;
                                o_wr_addr = w_head_dec;
                                o_wr_data = w_val;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        pbs_pkg::OP_GET: begin
                            if (w_pos_ok) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = f_phys(r_head, w_idx);
                            end else begin
                                n_res.status = pbs_pkg::ST_BADPOS;
                            end
                        end
                        pbs_pkg::OP_SET: begin
                            if (w_pos_ok) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = f_phys(r_head, w_idx);
                                o_wr_data = w_val;
                            end else begin
                                n_res.status = pbs_pkg::ST_BADPOS;
                            end
                        end
                        pbs_pkg::OP_INSERT: begin
                            priority if (!w_ins_ok) begin
                                n_res.status = pbs_pkg::ST_BADPOS;
                            end else if (w_full) begin
                                n_res.status = pbs_pkg::ST_FULL;
                            end else begin
                                n_idx = r_count;
                                n_pos = w_pos[CW-1:0];
                            end
                        end
                        pbs_pkg::OP_PUSHBACK: begin
                            if (w_full) begin
                                n_res.status = pbs_pkg::ST_FULL;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = f_phys(r_head, r_count);
                                o_wr_data = w_val;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        pbs_pkg::OP_POPFRONT: begin
                            if (w_empty) begin
                                n_res.status = pbs_pkg::ST_EMPTY;
                            end else begin
                                n_head  = w_head_inc;
                                n_count = r_count - CW'(1);
                            end
                        end
                        pbs_pkg::OP_POPBACK: begin
                            if (w_empty) begin
                                n_res.status = pbs_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        pbs_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pbs_pkg::S_SCAN: begin
                if (r_idx != r_count) begin
                    o_rd_en     = 1'b1;
                    o_rd_addr   = f_phys(r_head, r_idx);
                    n_idx       = r_idx + CW'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = f_phys(r_head, r_idx);
                end
                if (w_match) begin
                    n_hits  = r_hits + CW'(1);
                    n_match = r_pend_addr;
                end
                if (w_scan_end) begin
                    unique case (r_op)
                        pbs_pkg::OP_COUNT: n_res.data = DOW'(r_hits);
                        pbs_pkg::OP_CONTAINS: n_res.data = DOW'(r_hits != '0);
                        default: begin
                            n_res.status = pbs_pkg::ST_NOTFOUND;
                            n_res.data   = '0;
                        end
                    endcase
                end
            end
            pbs_pkg::S_HEAD_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_head;
            end
            pbs_pkg::S_HEAD_WR: begin
                o_wr_en      = 1'b1;
                o_wr_addr    = r_match;
                o_wr_data    = i_rd_data;
                n_head       = w_head_inc;
                n_count      = r_count - CW'(1);
                n_res.status = pbs_pkg::ST_OK;
                n_res.data   = DOW'(1);
            end
            pbs_pkg::S_GET: begin
                n_res.data = DOW'($signed(i_rd_data));
            end
            pbs_pkg::S_SHIFT: begin
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pend_addr;
                    o_wr_data = i_rd_data;
                end
                if (r_idx != r_pos) begin
                    o_rd_en     = 1'b1;
                    o_rd_addr   = f_phys(r_head, r_idx - CW'(1));
                    n_idx       = r_idx - CW'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = f_phys(r_head, r_idx);
                end else if (!r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = f_phys(r_head, r_pos);
                    o_wr_data = r_val;
                    n_count   = r_count + CW'(1);
                end
            end
            pbs_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase

        n_res.size = SZW'(n_count);
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbs_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_val       <= n_val;
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_hits      <= n_hits;
        r_match     <= n_match;
        r_pend_addr <= n_pend_addr;
        r_res       <= n_res;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= AW'(CAPACITY - 1))
        else $error("head pointer out of range");

    a_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && o_rd_en) |-> (o_wr_addr != o_rd_addr))
        else $error("read and write to the same entry in one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != pbs_pkg::S_IDLE))
        else $error("sequencer idle after accepting a transaction");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pbs_pkg::S_DONE && i_res_stall) |=>
            (r_state == pbs_pkg::S_DONE && $stable(r_res)))
        else $error("pending result lost while stalled");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for positional_bag_store: directed and random requests
// against a behavioural model of the ordered store. Depends on pbs_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

    localparam int CAP      = pbs_pkg::CAPACITY_DEF;
    localparam int N_RANDOM = 1400;
    localparam int V_MIN    = 32'h8000_0000;
    localparam int V_MAX    = 32'h7fff_ffff;

    typedef struct {
        logic [pbs_pkg::OP_W-1:0]           op;
        logic signed [pbs_pkg::VALUE_W-1:0] value;
        logic signed [pbs_pkg::POS_W-1:0]   pos;
        bit                                 drain;
    } t_bag_req;

    logic                                i_clk   = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic [pbs_pkg::OP_W-1:0]            i_op    = '0;
    logic signed [pbs_pkg::VALUE_W-1:0]  i_value = '0;
    logic signed [pbs_pkg::POS_W-1:0]    i_pos   = '0;
    logic                                i_stall = 1'b0;
    logic                                o_stall;
    logic                                o_valid;
    logic [pbs_pkg::STATUS_W-1:0]        o_status;
    logic signed [pbs_pkg::DOUT_W-1:0]   o_data;
    logic [pbs_pkg::SIZE_W-1:0]          o_size;

    positional_bag_store dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_op     (i_op),
        .i_value  (i_value),
        .i_pos    (i_pos),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status),
        .o_data   (o_data),
        .o_size   (o_size)
    );

    always #5 i_clk = ~i_clk;

    t_bag_req          pending_q[$];
    pbs_pkg::t_result  expected_q[$];
    logic signed [pbs_pkg::VALUE_W-1:0] bag_mem [0:CAP-1];
    int          bag_count;
    int          err_cnt;
    int unsigned sent_cnt;
    int unsigned checked_cnt;
    int          gen_size;
    int          value_pool [0:7];

    // Behavioural store: applies one accepted request, queues the result it must give.
    task automatic bag_predict(input t_bag_req r);
        pbs_pkg::t_result res;
        int      i;
        int      p;
        int      idx;
        int      hits;
        bit      ok;
        res.status = pbs_pkg::ST_OK;
        res.data   = '0;
        p          = r.pos;
        idx        = 0;
        ok         = 1'b0;
        if (p >= 0 && p < bag_count) begin
            idx = p;
            ok  = 1'b1;
        end else if (p < 0 && p >= -bag_count) begin
            idx = bag_count + p;
            ok  = 1'b1;
        end
        case (r.op)
            pbs_pkg::OP_ADD: begin
                if (bag_count >= CAP) begin
                    res.status = pbs_pkg::ST_FULL;
                end else begin
                    for (i = bag_count; i > 0; i--) bag_mem[i] = bag_mem[i-1];
                    bag_mem[0] = r.value;
                    bag_count++;
                end
            end
            pbs_pkg::OP_REMOVE: begin
                for (i = 0; i < bag_count; i++) if (bag_mem[i] == r.value) break;
                if (i == bag_count) begin
                    res.status = pbs_pkg::ST_NOTFOUND;
                end else begin
                    bag_mem[i] = bag_mem[0];
                    for (i = 0; i + 1 < bag_count; i++) bag_mem[i] = bag_mem[i+1];
                    bag_count--;
                    res.data = 1;
                end
            end
            pbs_pkg::OP_CONTAINS, pbs_pkg::OP_COUNT: begin
                hits = 0;
                for (i = 0; i < bag_count; i++) if (bag_mem[i] == r.value) hits++;
                res.data = (r.op == pbs_pkg::OP_COUNT) ? hits : int'(hits != 0);
            end
            pbs_pkg::OP_GET: begin
                if (ok) res.data = bag_mem[idx];
                else    res.status = pbs_pkg::ST_BADPOS;
            end
            pbs_pkg::OP_SET: begin
                if (ok) bag_mem[idx] = r.value;
                else    res.status = pbs_pkg::ST_BADPOS;
            end
            pbs_pkg::OP_INSERT: begin
                if (p < 0 || p > bag_count) begin
                    res.status = pbs_pkg::ST_BADPOS;
                end else if (bag_count >= CAP) begin
                    res.status = pbs_pkg::ST_FULL;
                end else begin
                    for (i = bag_count; i > p; i--) bag_mem[i] = bag_mem[i-1];
                    bag_mem[p] = r.value;
                    bag_count++;
                end
            end
            pbs_pkg::OP_PUSHBACK: begin
                if (bag_count >= CAP) begin
                    res.status = pbs_pkg::ST_FULL;
                end else begin
                    bag_mem[bag_count] = r.value;
                    bag_count++;
                end
            end
            pbs_pkg::OP_POPFRONT: begin
                if (bag_count == 0) begin
                    res.status = pbs_pkg::ST_EMPTY;
                end else begin
                    for (i = 0; i + 1 < bag_count; i++) bag_mem[i] = bag_mem[i+1];
                    bag_count--;
                end
            end
            pbs_pkg::OP_POPBACK: begin
                if (bag_count == 0) res.status = pbs_pkg::ST_EMPTY;
                else                bag_count--;
            end
            pbs_pkg::OP_CLEAR: bag_count = 0;
            default: ;
        endcase
        res.size = bag_count[pbs_pkg::SIZE_W-1:0];
        expected_q.insert(expected_q.size(), res);
    endtask

    task automatic flag_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= 100) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_result();
        pbs_pkg::t_result exp_res;
        if (expected_q.size() == 0) begin
            flag_mismatch("result with no request outstanding");
        end else begin
            exp_res = expected_q[0];
            expected_q.delete(0);
            if (o_status !== exp_res.status)
                flag_mismatch($sformatf("status %0d, want %0d", o_status, exp_res.status));
            if (o_data !== exp_res.data)
                flag_mismatch($sformatf("data %0d, want %0d", o_data, exp_res.data));
            if (o_size !== exp_res.size)
                flag_mismatch($sformatf("size %0d, want %0d", o_size, exp_res.size));
        end
    endtask

    // Driver
    t_bag_req drv_item;
    bit       drv_busy;
    int       drv_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_busy = 1'b0;
            drv_gap  = 0;
            drv_item = '{op: '0, value: '0, pos: '0, drain: 1'b0};
            i_valid <= 1'b0;
        end else begin
            if (drv_busy && !o_stall) begin
                bag_predict(drv_item);
                sent_cnt++;
                drv_busy = 1'b0;
                drv_gap  = ((sent_cnt / 150) % 3 == 1) ? 0 : $urandom_range(0, 12);
            end
            if (!drv_busy) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_q.size() != 0 &&
                             !(pending_q[0].drain && sent_cnt != checked_cnt)) begin
                    drv_item = pending_q[0];
                    pending_q.delete(0);
                    drv_busy = 1'b1;
                end
            end
            i_valid <= drv_busy;
            i_op    <= drv_item.op;
            i_value <= drv_item.value;
            i_pos   <= drv_item.pos;
        end
    end

    // Monitor
    int rx_wait;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_result();
                checked_cnt <= checked_cnt + 1;
                rx_wait = ((checked_cnt / 120) % 3 == 0) ? 0 : $urandom_range(0, 12);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_stall <= (rx_wait > 0);
        end
    end

    task automatic queue_item(input logic [pbs_pkg::OP_W-1:0] op, input int value,
                              input int pos, input bit drain = 1'b0);
        t_bag_req r;
        r.op    = op;
        r.value = value;
        r.pos   = pbs_pkg::POS_W'(pos);
        r.drain = drain;
        pending_q.insert(pending_q.size(), r);
        case (op)
            pbs_pkg::OP_ADD, pbs_pkg::OP_PUSHBACK: if (gen_size < CAP) gen_size++;
            pbs_pkg::OP_INSERT: if (pos >= 0 && pos <= gen_size && gen_size < CAP) gen_size++;
            pbs_pkg::OP_POPFRONT, pbs_pkg::OP_POPBACK: if (gen_size > 0) gen_size--;
            pbs_pkg::OP_CLEAR: gen_size = 0;
            default: ;
        endcase
    endtask

    function automatic int rand_value();
        return ($urandom_range(0, 99) < 65) ? value_pool[$urandom_range(0, 7)] : $urandom();
    endfunction

    function automatic int rand_pos(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    initial begin
        int k;
        int r;
        logic [pbs_pkg::OP_W-1:0] op;
        int pos;

        err_cnt     = 0;
        sent_cnt    = 0;
        checked_cnt = 0;
        bag_count   = 0;
        gen_size    = 0;
        value_pool  = '{0, -1, V_MIN, V_MAX, 1, 32'h5a5a_5a5a, 7, 32'h8000_0001};

        // directed: empty store, position edges, head overwrite on remove
        queue_item(pbs_pkg::OP_POPFRONT, 0, 0);
        queue_item(pbs_pkg::OP_POPBACK, 0, 0);
        queue_item(pbs_pkg::OP_REMOVE, 0, 0);
        queue_item(pbs_pkg::OP_GET, 0, 0);
        queue_item(pbs_pkg::OP_SET, 3, -1);
        queue_item(pbs_pkg::OP_INSERT, 4, 1);
        queue_item(pbs_pkg::OP_INSERT, 4, -1);
        queue_item(pbs_pkg::OP_INSERT, V_MIN, 0);
        queue_item(pbs_pkg::OP_ADD, V_MAX, 0);
        queue_item(pbs_pkg::OP_PUSHBACK, -1, 0);
        queue_item(pbs_pkg::OP_INSERT, 0, 3);
        queue_item(pbs_pkg::OP_INSERT, 5, 1);
        queue_item(pbs_pkg::OP_GET, 0, 5);
        queue_item(pbs_pkg::OP_GET, 0, -5);
        queue_item(pbs_pkg::OP_GET, 0, -6);
        queue_item(pbs_pkg::OP_GET, 0, 4);
        queue_item(pbs_pkg::OP_SET, 32'h1234_5678, -1);
        queue_item(pbs_pkg::OP_CONTAINS, 5, 0);
        queue_item(pbs_pkg::OP_COUNT, 9, 0);
        queue_item(pbs_pkg::OP_REMOVE, 32'h1234_5678, 0);
        queue_item(pbs_pkg::OP_REMOVE, 99, 0);
        queue_item(4'd11, V_MAX, 511);
        queue_item(4'd15, -1, -512);
        queue_item(pbs_pkg::OP_CLEAR, 0, 0);
        queue_item(pbs_pkg::OP_PUSHBACK, 42, 0);
        queue_item(pbs_pkg::OP_POPBACK, 0, 0);

        // fill to capacity, then hit every full-store and far-position case
        queue_item(pbs_pkg::OP_PUSHBACK, rand_value(), 0, 1'b1);
        for (k = 1; k < CAP; k++) queue_item(pbs_pkg::OP_PUSHBACK, rand_value(), 0);
        queue_item(pbs_pkg::OP_ADD, 3, 0);
        queue_item(pbs_pkg::OP_PUSHBACK, 3, 0);
        queue_item(pbs_pkg::OP_INSERT, 3, CAP);
        queue_item(pbs_pkg::OP_INSERT, 3, -1);
        queue_item(pbs_pkg::OP_GET, 0, CAP - 1);
        queue_item(pbs_pkg::OP_GET, 0, -CAP);
        queue_item(pbs_pkg::OP_GET, 0, CAP);
        queue_item(pbs_pkg::OP_SET, V_MIN, -CAP);
        queue_item(pbs_pkg::OP_COUNT, value_pool[0], 0);
        queue_item(pbs_pkg::OP_CONTAINS, $urandom(), 0);
        queue_item(pbs_pkg::OP_POPFRONT, 0, 0);
        queue_item(pbs_pkg::OP_INSERT, V_MAX, 0);
        queue_item(pbs_pkg::OP_REMOVE, value_pool[1], 0);
        queue_item(pbs_pkg::OP_POPBACK, 0, 0);
        queue_item(pbs_pkg::OP_CLEAR, 0, 0);

        for (k = 0; k < N_RANDOM; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                op = pbs_pkg::OP_W'($urandom_range(11, 15));
            end else if (r < 5) begin
                op = pbs_pkg::OP_CLEAR;
            end else if (r < 35 && gen_size < 40) begin
                case ($urandom_range(0, 2))
                    0:       op = pbs_pkg::OP_ADD;
                    1:       op = pbs_pkg::OP_INSERT;
                    default: op = pbs_pkg::OP_PUSHBACK;
                endcase
            end else if (r < 55) begin
                case ($urandom_range(0, 2))
                    0:       op = pbs_pkg::OP_POPFRONT;
                    1:       op = pbs_pkg::OP_POPBACK;
                    default: op = pbs_pkg::OP_REMOVE;
                endcase
            end else begin
                case ($urandom_range(0, 3))
                    0:       op = pbs_pkg::OP_CONTAINS;
                    1:       op = pbs_pkg::OP_COUNT;
                    2:       op = pbs_pkg::OP_GET;
                    default: op = pbs_pkg::OP_SET;
                endcase
            end
            if ($urandom_range(0, 99) < 15)         pos = rand_pos(CAP);
            else if (op == pbs_pkg::OP_INSERT)      pos = $urandom_range(0, gen_size);
            else                                    pos = rand_pos(gen_size);
            queue_item(op, rand_value(), pos, (k % 200) == 199);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || drv_busy || sent_cnt != checked_cnt)
            @(negedge i_clk);
        repeat (2 * CAP + 16) @(negedge i_clk);
        if (expected_q.size() != 0) flag_mismatch("expected results never arrived");

        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
